/* hw/rtl/biou_pkg.sv */
package biou_pkg;

  // field widths
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned AREA_W  = 2 * COORD_W;
  localparam int unsigned UNI_W   = AREA_W + 1;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned NUM_W   = AREA_W + Q_W;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS = Q_W;

  // 1.0 in q1.16
  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0]  area_t;
  typedef logic [UNI_W-1:0]   uni_t;
  typedef logic [Q_W-1:0]     ratio_t;

  // payload carried through the divider stages
  typedef struct packed {
    idx_t   row;
    idx_t   col;
    logic   empty;
    uni_t   den;
    uni_t   rem;
    ratio_t low;
    ratio_t quo;
  } div_t;

endpackage

/* hw/rtl/box_iou_distance.sv */
// box_iou_distance: iou cost of one track box against one detection box
//
// pair channel: pair_valid / pair_stall carry one beat per box pair, with
// indices and both boxes as left, top, width, height in unsigned q12.4.
// cost channel: cost_valid / cost_stall carry one beat per pair with the
// echoed indices, iou in q1.16, 1.0 - iou and the empty-union flag.
//
// a pair is taken every cycle while pair_stall is low; results leave in pair
// order. the pipeline is four arithmetic stages (overlap, area multipliers,
// union, dividend) followed by a restoring divider that resolves one quotient
// bit per stage over 17 stages, then an output register, 22 register stages
// in all.
//
// a stall on the cost channel freezes the whole pipeline and raises
// pair_stall in the same cycle, so nothing is lost or repeated.
// reset clears all valid bits; the block keeps no state between pairs.
module box_iou_distance (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  biou_pkg::idx_t       track_index,
  input  biou_pkg::idx_t       detect_index,
  input  biou_pkg::coord_t     trk_left,
  input  biou_pkg::coord_t     trk_top,
  input  biou_pkg::coord_t     trk_width,
  input  biou_pkg::coord_t     trk_height,
  input  biou_pkg::coord_t     det_left,
  input  biou_pkg::coord_t     det_top,
  input  biou_pkg::coord_t     det_width,
  input  biou_pkg::coord_t     det_height,
  output logic                 cost_valid,
  input  logic                 cost_stall,
  output biou_pkg::idx_t       row_tag,
  output biou_pkg::idx_t       col_tag,
  output biou_pkg::ratio_t     overlap_ratio,
  output biou_pkg::ratio_t     iou_distance,
  output logic                 union_empty
);
  import biou_pkg::*;

  logic adv;

  // whole pipeline moves unless the output beat is held
  assign adv        = !(cost_valid && cost_stall);
  assign pair_stall = !adv;

  // stage 1: overlap along each axis
  logic [COORD_W:0] t_right, t_bottom, d_right, d_bottom;
  logic [COORD_W:0] x_hi, y_hi, x_diff, y_diff;
  coord_t           x_lo, y_lo, ow_next, oh_next;

  assign t_right  = {1'b0, trk_left} + {1'b0, trk_width};
  assign d_right  = {1'b0, det_left} + {1'b0, det_width};
  assign t_bottom = {1'b0, trk_top} + {1'b0, trk_height};
  assign d_bottom = {1'b0, det_top} + {1'b0, det_height};
  assign x_lo     = (trk_left > det_left) ? trk_left : det_left;
  assign y_lo     = (trk_top > det_top) ? trk_top : det_top;
  assign x_hi     = (t_right < d_right) ? t_right : d_right;
  assign y_hi     = (t_bottom < d_bottom) ? t_bottom : d_bottom;
  assign x_diff   = x_hi - {1'b0, x_lo};
  assign y_diff   = y_hi - {1'b0, y_lo};
  assign ow_next  = (x_hi > {1'b0, x_lo}) ? x_diff[COORD_W-1:0] : '0;
  assign oh_next  = (y_hi > {1'b0, y_lo}) ? y_diff[COORD_W-1:0] : '0;

  logic   s1_valid;
  idx_t   s1_row, s1_col;
  coord_t s1_ow, s1_oh, s1_tw, s1_th, s1_dw, s1_dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pair_valid;
    end
    if (adv) begin
      s1_row <= track_index;
      s1_col <= detect_index;
      s1_ow  <= ow_next;
      s1_oh  <= oh_next;
      s1_tw  <= trk_width;
      s1_th  <= trk_height;
      s1_dw  <= det_width;
      s1_dh  <= det_height;
    end
  end

  // stage 2: intersection and box areas
  logic  s2_valid;
  idx_t  s2_row, s2_col;
  area_t s2_inter, s2_ta, s2_da;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_inter <= s1_ow * s1_oh;
      s2_ta    <= s1_tw * s1_th;
      s2_da    <= s1_dw * s1_dh;
    end
  end

  // stage 3: union area
  uni_t uni_next;

  assign uni_next = {1'b0, s2_ta} + {1'b0, s2_da} - {1'b0, s2_inter};

  logic  s3_valid;
  idx_t  s3_row, s3_col;
  area_t s3_inter;
  uni_t  s3_uni;
  logic  s3_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s3_row   <= s2_row;
      s3_col   <= s2_col;
      s3_inter <= s2_inter;
      s3_uni   <= uni_next;
      s3_empty <= (uni_next == '0);
    end
  end

  // stage 4: rounded dividend, split into start remainder and low bits
  logic [NUM_W-1:0] num;
  div_t             div_init;

  assign num = {s3_inter, 16'h0000} + NUM_W'(s3_uni[UNI_W-1:1]);

  always_comb begin
    div_init.row   = s3_row;
    div_init.col   = s3_col;
    div_init.empty = s3_empty;
    div_init.den   = s3_uni;
    div_init.rem   = {1'b0, num[NUM_W-1:Q_W]};
    div_init.low   = num[Q_W-1:0];
    div_init.quo   = '0;
  end

  logic d_valid [DIV_STEPS+1];
  div_t d_data  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= s3_valid;
    end
    if (adv) begin
      d_data[0] <= div_init;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [UNI_W:0] trial, diff;
    logic           ge;
    div_t           step_next;

    assign trial = {d_data[k].rem, d_data[k].low[Q_W-1]};
    assign ge    = (trial >= {1'b0, d_data[k].den});
    assign diff  = trial - {1'b0, d_data[k].den};

    always_comb begin
      step_next     = d_data[k];
      step_next.rem = ge ? diff[UNI_W-1:0] : trial[UNI_W-1:0];
      step_next.low = {d_data[k].low[Q_W-2:0], 1'b0};
      step_next.quo = {d_data[k].quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d_valid[k+1] <= d_valid[k];
      end
      if (adv) begin
        d_data[k+1] <= step_next;
      end
    end
  end

  // output register: empty union forces iou to zero, a ratio above one clamps to one
  ratio_t quo_last, ratio_next;

  assign quo_last   = d_data[DIV_STEPS].quo;
  assign ratio_next = d_data[DIV_STEPS].empty ? '0 :
                      ((quo_last > ONE_Q16) ? ONE_Q16 : quo_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_valid <= 1'b0;
    end else if (adv) begin
      cost_valid <= d_valid[DIV_STEPS];
    end
    if (adv) begin
      row_tag       <= d_data[DIV_STEPS].row;
      col_tag       <= d_data[DIV_STEPS].col;
      overlap_ratio <= ratio_next;
      iou_distance  <= ONE_Q16 - ratio_next;
      union_empty   <= d_data[DIV_STEPS].empty;
    end
  end

  // checks
  a_sum_is_one: assert property (@(posedge clk) disable iff (rst)
    cost_valid |-> (overlap_ratio + iou_distance == ONE_Q16))
    else $error("iou and distance do not add up to one");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (cost_valid && union_empty) |-> (overlap_ratio == '0))
    else $error("empty union with nonzero iou");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    cost_valid |-> (overlap_ratio <= ONE_Q16))
    else $error("iou above one");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !cost_valid |-> !pair_stall)
    else $error("input stalled with no output beat pending");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !cost_valid)
    else $error("output beat right after reset");

endmodule
